[sv/sidac_pkg.sv]
`default_nettype none

package sidac_pkg;

    localparam int BITS_PER_STEP = 4;
    localparam int COUNT_W       = 4;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_COUNT,
        ST_EMIT
    } sidac_state_t;

endpackage

`default_nettype wire

[sv/signed_int_to_decimal_ascii_unit.sv]
`default_nettype none

// Converts one signed VALUE_WIDTH-bit integer per item into its decimal ASCII text, one
// character per output item, most significant first, with a leading '-' for negative values
// and a single '0' for zero; the most negative value prints its true magnitude. last_char
// marks the final character, which also carries the character count (low 4 bits) in
// char_count. An item passes through conversion, a digit count and emission: the magnitude goes
// through one shift-add-3 unit four bits per cycle, the ST_COUNT state finds the digit count, then
// one character is loaded per cycle into the output register while that register is free or being
// taken. in_ready is high only between items.
module signed_int_to_decimal_ascii_unit import sidac_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [VALUE_WIDTH-1:0] value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic             [7:0]             char_code,
    output logic                               last_char,
    output logic             [COUNT_W-1:0]     char_count
);

    localparam int STEPS  = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int MAG_W  = STEPS * BITS_PER_STEP;
    localparam int NDIG   = (VALUE_WIDTH * 3) / 10 + 1;
    localparam int BCD_W  = NDIG * 4;
    localparam int IDX_W  = $clog2(NDIG);
    localparam int NDIG_W = $clog2(NDIG + 1);
    localparam int STEP_W = $clog2(STEPS);
    localparam int TOT_W  = (NDIG_W + 1 > COUNT_W) ? NDIG_W + 1 : COUNT_W;

    sidac_state_t state_reg, state_next;

    logic [STEP_W-1:0]  step_reg, step_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [NDIG_W-1:0]  ndig_reg, ndig_next;
    logic               neg_reg, neg_next;
    logic               sign_pend_reg, sign_pend_next;
    logic [MAG_W-1:0]   mag_reg, mag_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;

    logic               out_valid_reg, out_valid_next;
    logic [7:0]         char_code_reg, char_code_next;
    logic               last_char_reg, last_char_next;
    logic [COUNT_W-1:0] char_count_reg, char_count_next;

    logic [VALUE_WIDTH-1:0] value_u;
    logic [VALUE_WIDTH-1:0] abs_val;
    logic [BCD_W-1:0]       bcd_step;
    logic [MAG_W-1:0]       mag_step;
    logic [NDIG_W-1:0]      ndig_found;
    logic [3:0]             cur_digit;
    logic [TOT_W-1:0]       total_wide;
    logic                   accept;
    logic                   slot_free;
    logic                   load;
    logic                   conv_done;

    sidac_dabble #(
        .NDIG  (NDIG),
        .MAG_W (MAG_W)
    ) u_dabble (
        .bcd_in  (bcd_reg),
        .mag_in  (mag_reg),
        .bcd_out (bcd_step),
        .mag_out (mag_step)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign load      = (state_reg == ST_EMIT) && slot_free;
    assign conv_done = (step_reg == STEP_W'(STEPS - 1));

    assign value_u = value;
    assign abs_val = value_u[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - value_u) : value_u;

    // most significant nonzero digit sets the digit count, at least one digit
    always_comb
    begin
        ndig_found = NDIG_W'(1);
        for (int d = 0; d < NDIG; d++)
        begin
            if (bcd_reg[d*4 +: 4] != 4'd0)
            begin
                ndig_found = NDIG_W'(d + 1);
            end
        end
    end

    assign cur_digit  = bcd_reg[idx_reg*4 +: 4];
    assign total_wide = TOT_W'(ndig_reg) + TOT_W'(neg_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (conv_done)
                begin
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (load && !sign_pend_reg && (idx_reg == IDX_W'(0)))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and output register
    always_comb
    begin
        step_next       = step_reg;
        idx_next        = idx_reg;
        ndig_next       = ndig_reg;
        neg_next        = neg_reg;
        sign_pend_next  = sign_pend_reg;
        mag_next        = mag_reg;
        bcd_next        = bcd_reg;
        char_code_next  = char_code_reg;
        last_char_next  = last_char_reg;
        char_count_next = char_count_reg;
        out_valid_next  = out_ready ? 1'b0 : out_valid_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next  = value_u[VALUE_WIDTH-1];
                    mag_next  = MAG_W'(abs_val);
                    bcd_next  = '0;
                    step_next = '0;
                end
            end
            ST_CONV:
            begin
                mag_next  = mag_step;
                bcd_next  = bcd_step;
                step_next = step_reg + STEP_W'(1);
            end
            ST_COUNT:
            begin
                ndig_next      = ndig_found;
                idx_next       = IDX_W'(ndig_found - NDIG_W'(1));
                sign_pend_next = neg_reg;
            end
            ST_EMIT:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    if (sign_pend_reg)
                    begin
                        char_code_next  = CH_MINUS;
                        last_char_next  = 1'b0;
                        char_count_next = '0;
                        sign_pend_next  = 1'b0;
                    end
                    else
                    begin
                        char_code_next = CH_ZERO + {4'd0, cur_digit};
                        if (idx_reg == IDX_W'(0))
                        begin
                            last_char_next  = 1'b1;
                            char_count_next = total_wide[COUNT_W-1:0];
                        end
                        else
                        begin
                            last_char_next  = 1'b0;
                            char_count_next = '0;
                            idx_next        = idx_reg - IDX_W'(1);
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            idx_reg       <= '0;
            ndig_reg      <= '0;
            neg_reg       <= 1'b0;
            sign_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            idx_reg       <= idx_next;
            ndig_reg      <= ndig_next;
            neg_reg       <= neg_next;
            sign_pend_reg <= sign_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg        <= mag_next;
        bcd_reg        <= bcd_next;
        char_code_reg  <= char_code_next;
        last_char_reg  <= last_char_next;
        char_count_reg <= char_count_next;
    end

    assign out_valid  = out_valid_reg;
    assign char_code  = char_code_reg;
    assign last_char  = last_char_reg;
    assign char_count = char_count_reg;

    // every non-sign character is a decimal digit
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (char_code != CH_MINUS)) |->
            ((char_code >= CH_ZERO) && (char_code <= (CH_ZERO + 8'd9))))
        else $error("non-digit character emitted");

    // the sign is never the final character
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (char_code == CH_MINUS)) |-> !last_char)
        else $error("minus sign flagged as last character");

    // an accepted item starts conversion right away
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_CONV))
        else $error("accepted item did not start conversion");

endmodule

`default_nettype wire

[sv/sidac_dabble.sv]
`default_nettype none

module sidac_dabble import sidac_pkg::*; #(
    parameter int NDIG  = 10,
    parameter int MAG_W = 32
) (
    input  wire logic [NDIG*4-1:0] bcd_in,
    input  wire logic [MAG_W-1:0]  mag_in,
    output logic      [NDIG*4-1:0] bcd_out,
    output logic      [MAG_W-1:0]  mag_out
);

    localparam int BCD_W = NDIG * 4;

    logic [BCD_W-1:0] bcd_w;
    logic [MAG_W-1:0] mag_w;

    // shift-add-3: BITS_PER_STEP binary bits move into the bcd digits per call
    always_comb
    begin
        bcd_w = bcd_in;
        mag_w = mag_in;
        for (int b = 0; b < BITS_PER_STEP; b++)
        begin
            for (int d = 0; d < NDIG; d++)
            begin
                if (bcd_w[d*4 +: 4] >= 4'd5)
                begin
                    bcd_w[d*4 +: 4] = bcd_w[d*4 +: 4] + 4'd3;
                end
            end
            {bcd_w, mag_w} = {bcd_w[BCD_W-2:0], mag_w, 1'b0};
        end
    end

    assign bcd_out = bcd_w;
    assign mag_out = mag_w;

endmodule

`default_nettype wire

[verif/decimal_text_checker.sv]
module decimal_text_checker import sidac_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic                   in_ready,
    input  wire logic [VALUE_WIDTH-1:0] value,
    input  wire logic                   out_valid,
    input  wire logic                   out_ready,
    input  wire logic [7:0]             char_code,
    input  wire logic                   last_char,
    input  wire logic [COUNT_W-1:0]     char_count,
    output int                          mismatches,
    output int                          pending_chars
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0]         code;
        logic               last;
        logic [COUNT_W-1:0] count;
    } text_char_t;

    text_char_t expected_text[$];

    initial
    begin
        mismatches    = 0;
        pending_chars = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // digits of the magnitude, least significant first, then pushed in text order
    task automatic predict_decimal_text(input logic [VALUE_WIDTH-1:0] word);
        logic                   negative;
        logic [VALUE_WIDTH-1:0] magnitude;
        int                     digit_buf[24];
        int                     ndigits;
        int                     total;
        int                     slot;
        text_char_t             entry;
        negative  = word[VALUE_WIDTH-1];
        // most negative value wraps to itself, which is its true magnitude
        magnitude = negative ? (~word + 1'b1) : word;
        ndigits   = 0;
        if (magnitude == '0)
        begin
            digit_buf[0] = 0;
            ndigits      = 1;
        end
        while (magnitude != '0)
        begin
            digit_buf[ndigits] = int'(magnitude % 10);
            magnitude          = magnitude / 10;
            ndigits++;
        end
        total = ndigits + (negative ? 1 : 0);
        slot  = 0;
        if (negative)
        begin
            entry.code  = CH_MINUS;
            entry.last  = (slot == total - 1);
            entry.count = entry.last ? COUNT_W'(total) : '0;
            expected_text.push_back(entry);
            slot++;
        end
        for (int i = ndigits - 1; i >= 0; i--)
        begin
            entry.code  = CH_ZERO + 8'(digit_buf[i]);
            entry.last  = (slot == total - 1);
            entry.count = entry.last ? COUNT_W'(total) : '0;
            expected_text.push_back(entry);
            slot++;
        end
    endtask

    always @(posedge clk)
    begin
        text_char_t wanted;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                predict_decimal_text(value);
            if (out_valid && out_ready)
            begin
                if (expected_text.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected item, char_code %0h", char_code));
                end
                else
                begin
                    wanted = expected_text.pop_front();
                    if (char_code !== wanted.code)
                        report_mismatch($sformatf("char_code is %0d, expected %0d",
                            char_code, wanted.code));
                    if (last_char !== wanted.last)
                        report_mismatch($sformatf("last_char is %0d, expected %0d",
                            last_char, wanted.last));
                    if (char_count !== wanted.count)
                        report_mismatch($sformatf("char_count is %0d, expected %0d",
                            char_count, wanted.count));
                end
            end
        end
        pending_chars <= expected_text.size();
    end

endmodule

[verif/signed_int_to_decimal_ascii_unit_test.sv]
module signed_int_to_decimal_ascii_unit_test import sidac_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_WIDTH  = 32;
    localparam int RANDOM_ITEMS = 258;
    localparam int CALM_ITEMS   = 40;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          out_valid;
    logic                          out_ready;
    logic        [7:0]             char_code;
    logic                          last_char;
    logic        [COUNT_W-1:0]     char_count;
    int                            mismatches;
    int                            pending_chars;
    bit                            quiet_phase;

    logic [VALUE_WIDTH-1:0] directed_values[] = '{
        32'd0, 32'd1, -32'sd1, 32'd5, 32'd9, -32'sd9, 32'd10, -32'sd10,
        32'd99, 32'd100, -32'sd100, 32'd12345, -32'sd54321,
        32'd999999999, 32'd1000000000, -32'sd1000000000,
        32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000,
        32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F
    };

    signed_int_to_decimal_ascii_unit #(.VALUE_WIDTH(VALUE_WIDTH)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .char_code  (char_code),
        .last_char  (last_char),
        .char_count (char_count)
    );

    decimal_text_checker #(.VALUE_WIDTH(VALUE_WIDTH)) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .value         (value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .char_code     (char_code),
        .last_char     (last_char),
        .char_count    (char_count),
        .mismatches    (mismatches),
        .pending_chars (pending_chars)
    );

    always #2 clk = ~clk;

    // mostly values of a chosen digit count, some fully random words
    function automatic logic [VALUE_WIDTH-1:0] pick_value();
        longint limit;
        longint magnitude;
        int     ndigits;
        if ($urandom_range(0, 3) == 0)
            return $urandom();
        ndigits = $urandom_range(1, 10);
        limit   = 1;
        for (int i = 0; i < ndigits; i++)
            limit = limit * 10;
        if (limit > 64'sd2147483649)
            limit = 64'sd2147483649;
        magnitude = {$urandom(), $urandom()} % limit;
        if ($urandom_range(0, 1) == 1)
            return VALUE_WIDTH'(-magnitude);
        if (magnitude > 64'sd2147483647)
            magnitude = 64'sd2147483647;
        return VALUE_WIDTH'(magnitude);
    endfunction

    task automatic send_value(input logic [VALUE_WIDTH-1:0] word);
        int gap;
        gap = (!quiet_phase && $urandom_range(0, 2) == 0) ? $urandom_range(1, 11) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= word;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!quiet_phase && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        value       = '0;
        quiet_phase = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_values[i])
            send_value(directed_values[i]);
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS - CALM_ITEMS)
                quiet_phase = 1'b1;
            send_value(pick_value());
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_chars != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (mismatches == 0 && pending_chars == 0)
            $display("signed_int_to_decimal_ascii_unit test passed");
        else
            $display("signed_int_to_decimal_ascii_unit test failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("signed_int_to_decimal_ascii_unit test failed");
        $finish;
    end

endmodule
